@@ design/oering_pkg.sv @@
// Shared types, widths and codes for the overwriting entry ring.
// No dependencies.
`timescale 1ns / 1ps

package oering_pkg;

  localparam int RING_DEPTH_DEF = 16;

  localparam int OP_W     = 2;
  localparam int HANDLE_W = 32;
  localparam int SIZE_W   = 20;
  localparam int POS_W    = 24;
  localparam int STAT_W   = 2;

  localparam logic [OP_W-1:0] OP_ADD  = 2'd0;
  localparam logic [OP_W-1:0] OP_READ = 2'd1;
  localparam logic [OP_W-1:0] OP_FIND = 2'd2;

  localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
  localparam logic [STAT_W-1:0] ST_EMPTY     = 2'd1;
  localparam logic [STAT_W-1:0] ST_NOT_FOUND = 2'd2;

  typedef struct packed {
    logic [HANDLE_W-1:0] handle;
    logic [SIZE_W-1:0]   size;
  } slot_t;

  typedef struct packed {
    logic accept;
    logic add_commit;
    logic read_commit;
    logic walk;
  } ctl_cmd_t;

  typedef struct packed {
    logic walk_done;
  } dp_stat_t;

endpackage

@@ design/oering_ctrl.sv @@
// Controller state machine for the overwriting entry ring.
// Depends on oering_pkg.
`timescale 1ns / 1ps

module oering_ctrl (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [oering_pkg::OP_W-1:0]   in_operation,
  input  oering_pkg::dp_stat_t          stat,
  output oering_pkg::ctl_cmd_t          cmd,
  output logic                          busy
);
  import oering_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_ADD  = 2'd1;
  localparam logic [1:0] S_READ = 2'd2;
  localparam logic [1:0] S_FIND = 2'd3;

  logic [1:0] state_r;
  logic [1:0] state_nxt;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          unique case (in_operation)
            OP_ADD:  state_nxt = S_ADD;
            OP_READ: state_nxt = S_READ;
            OP_FIND: state_nxt = S_FIND;
            default: state_nxt = S_IDLE;
          endcase
        end
      end
      S_ADD:  state_nxt = S_IDLE;
      S_READ: state_nxt = S_IDLE;
      S_FIND: begin
        if (stat.walk_done) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy            = (state_r != S_IDLE);
  assign cmd.accept      = (state_r == S_IDLE) && start;
  assign cmd.add_commit  = (state_r == S_ADD);
  assign cmd.read_commit = (state_r == S_READ);
  assign cmd.walk        = (state_r == S_FIND);

endmodule

@@ design/oering_dp.sv @@
// Datapath for the overwriting entry ring: slot memory, ring indexes,
// offset walk and result registers. Depends on oering_pkg.
`timescale 1ns / 1ps

module oering_dp #(
  parameter int RING_DEPTH = oering_pkg::RING_DEPTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  oering_pkg::ctl_cmd_t              cmd,
  output oering_pkg::dp_stat_t              stat,
  input  logic [oering_pkg::OP_W-1:0]       in_operation,
  input  logic [oering_pkg::HANDLE_W-1:0]   in_new_handle,
  input  logic [oering_pkg::SIZE_W-1:0]     in_new_size,
  input  logic [oering_pkg::POS_W-1:0]      in_char_position,
  output logic                              out_valid,
  output logic [oering_pkg::STAT_W-1:0]     out_status,
  output logic [oering_pkg::HANDLE_W-1:0]   out_entry_handle,
  output logic [oering_pkg::SIZE_W-1:0]     out_entry_bytes,
  output logic [oering_pkg::SIZE_W-1:0]     out_byte_in_entry,
  output logic                              out_evicted_valid,
  output logic [oering_pkg::HANDLE_W-1:0]   out_evicted_handle
);
  import oering_pkg::*;

  localparam int IDX_W = $clog2(RING_DEPTH);
  localparam int CNT_W = $clog2(RING_DEPTH + 1);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(RING_DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(RING_DEPTH);

  function automatic logic [IDX_W-1:0] next_idx(input logic [IDX_W-1:0] idx);
    next_idx = (idx == LAST_IDX) ? '0 : idx + 1'b1;
  endfunction

  slot_t mem [RING_DEPTH];
  slot_t rd_data_r;

  logic [HANDLE_W-1:0] handle_r;
  logic [SIZE_W-1:0]   size_r;
  logic [IDX_W-1:0]    wr_idx_r, wr_idx_nxt;
  logic [IDX_W-1:0]    rd_idx_r, rd_idx_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [IDX_W-1:0]    walk_addr_r;
  logic [CNT_W-1:0]    walk_cnt_r;
  logic [POS_W-1:0]    remaining_r;
  logic [IDX_W-1:0]    rd_addr;
  logic                full;
  logic                hit;
  logic                at_end;

  logic                valid_nxt;
  logic [STAT_W-1:0]   status_nxt;
  logic [HANDLE_W-1:0] ehandle_nxt;
  logic [SIZE_W-1:0]   ebytes_nxt;
  logic [SIZE_W-1:0]   bie_nxt;
  logic                evv_nxt;
  logic [HANDLE_W-1:0] evh_nxt;

  assign full   = (cnt_r == FULL_CNT);
  assign hit    = (remaining_r < {{(POS_W - SIZE_W){1'b0}}, rd_data_r.size});
  assign at_end = (walk_cnt_r == cnt_r);
  assign stat.walk_done = at_end || hit;

  always_comb begin
    if (cmd.accept) begin
      rd_addr = (in_operation == OP_ADD) ? wr_idx_r : rd_idx_r;
    end else begin
      rd_addr = walk_addr_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.add_commit) begin
      mem[wr_idx_r] <= '{handle: handle_r, size: size_r};
    end
    rd_data_r <= mem[rd_addr];
  end

  always_comb begin
    wr_idx_nxt  = wr_idx_r;
    rd_idx_nxt  = rd_idx_r;
    cnt_nxt     = cnt_r;
    valid_nxt   = 1'b0;
    status_nxt  = ST_OK;
    ehandle_nxt = '0;
    ebytes_nxt  = '0;
    bie_nxt     = '0;
    evv_nxt     = 1'b0;
    evh_nxt     = '0;
    priority if (cmd.accept) begin
      valid_nxt = !(in_operation == OP_ADD || in_operation == OP_READ ||
                    in_operation == OP_FIND);
    end else if (cmd.add_commit) begin
      valid_nxt  = 1'b1;
      wr_idx_nxt = next_idx(wr_idx_r);
      if (full) begin
        evv_nxt    = 1'b1;
        evh_nxt    = rd_data_r.handle;
        rd_idx_nxt = next_idx(wr_idx_r);
      end else begin
        cnt_nxt = cnt_r + 1'b1;
      end
    end else if (cmd.read_commit) begin
      valid_nxt = 1'b1;
      if (cnt_r == '0) begin
        status_nxt = ST_EMPTY;
      end else begin
        ehandle_nxt = rd_data_r.handle;
        ebytes_nxt  = rd_data_r.size;
        rd_idx_nxt  = next_idx(rd_idx_r);
        cnt_nxt     = cnt_r - 1'b1;
      end
    end else if (cmd.walk) begin
      if (at_end) begin
        valid_nxt  = 1'b1;
        status_nxt = ST_NOT_FOUND;
      end else if (hit) begin
        valid_nxt   = 1'b1;
        ehandle_nxt = rd_data_r.handle;
        ebytes_nxt  = rd_data_r.size;
        bie_nxt     = remaining_r[SIZE_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_idx_r  <= '0;
      rd_idx_r  <= '0;
      cnt_r     <= '0;
      out_valid <= 1'b0;
    end else begin
      wr_idx_r  <= wr_idx_nxt;
      rd_idx_r  <= rd_idx_nxt;
      cnt_r     <= cnt_nxt;
      out_valid <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_status         <= status_nxt;
    out_entry_handle   <= ehandle_nxt;
    out_entry_bytes    <= ebytes_nxt;
    out_byte_in_entry  <= bie_nxt;
    out_evicted_valid  <= evv_nxt;
    out_evicted_handle <= evh_nxt;
    if (cmd.accept) begin
      handle_r    <= in_new_handle;
      size_r      <= in_new_size;
      remaining_r <= in_char_position;
      walk_cnt_r  <= '0;
      walk_addr_r <= next_idx(rd_idx_r);
    end else if (cmd.walk) begin
      remaining_r <= remaining_r - {{(POS_W - SIZE_W){1'b0}}, rd_data_r.size};
      walk_cnt_r  <= walk_cnt_r + 1'b1;
      walk_addr_r <= next_idx(walk_addr_r);
    end
  end

endmodule

@@ design/overwriting_entry_ring_with_offset_find.sv @@
// Overwriting entry ring with offset find.
// Commands enter on start/in_* while busy is low; a word is taken on the
// edge where start is high and busy is low. Operations: add an entry
// (overwrites and reports the oldest when the ring is full), read and pop
// the oldest entry, or find the entry holding a character offset into all
// stored entries, oldest first.
// Each command gives one result word on out_*, marked by out_valid for one
// cycle; the receiver cannot stall, so results are never held back.
// Add and read results are registered after the S_ADD or S_READ state, an
// unused operation's straight after it is accepted in idle, and a find's
// after a walk of k entries (at most the stored count, RING_DEPTH at most).
// The walk reads one slot per cycle through the slot memory's single read
// port; busy stays high until the result is out. A new command may be taken
// in the cycle its predecessor's result shows. Reset (rst_n low, synchronous)
// empties the ring; slot contents are not cleared.
// Depends on oering_pkg, oering_ctrl, oering_dp.
`timescale 1ns / 1ps

module overwriting_entry_ring_with_offset_find #(
  parameter int RING_DEPTH = oering_pkg::RING_DEPTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic [oering_pkg::OP_W-1:0]       in_operation,
  input  logic [oering_pkg::HANDLE_W-1:0]   in_new_handle,
  input  logic [oering_pkg::SIZE_W-1:0]     in_new_size,
  input  logic [oering_pkg::POS_W-1:0]      in_char_position,
  output logic                              out_valid,
  output logic [oering_pkg::STAT_W-1:0]     out_status,
  output logic [oering_pkg::HANDLE_W-1:0]   out_entry_handle,
  output logic [oering_pkg::SIZE_W-1:0]     out_entry_bytes,
  output logic [oering_pkg::SIZE_W-1:0]     out_byte_in_entry,
  output logic                              out_evicted_valid,
  output logic [oering_pkg::HANDLE_W-1:0]   out_evicted_handle
);
  import oering_pkg::*;

  ctl_cmd_t cmd;
  dp_stat_t stat;

  oering_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .in_operation (in_operation),
    .stat         (stat),
    .cmd          (cmd),
    .busy         (busy)
  );

  oering_dp #(
    .RING_DEPTH (RING_DEPTH)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .stat               (stat),
    .in_operation       (in_operation),
    .in_new_handle      (in_new_handle),
    .in_new_size        (in_new_size),
    .in_char_position   (in_char_position),
    .out_valid          (out_valid),
    .out_status         (out_status),
    .out_entry_handle   (out_entry_handle),
    .out_entry_bytes    (out_entry_bytes),
    .out_byte_in_entry  (out_byte_in_entry),
    .out_evicted_valid  (out_evicted_valid),
    .out_evicted_handle (out_evicted_handle)
  );

endmodule

@@ verif/overwriting_entry_ring_with_offset_find_tb.sv @@
// Self-checking bench for the overwriting entry ring: adds, reads and offset finds
// are predicted by a scoreboard class and checked word by word against out_*.
// Depends on oering_pkg and overwriting_entry_ring_with_offset_find.
`timescale 1ns / 1ps

module overwriting_entry_ring_with_offset_find_tb;
  import oering_pkg::*;

  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT = 400000;
  localparam int RANDOM_WORDS = 1080;
  localparam int CALM_FROM = 940;

  typedef enum int {MODE_FILL, MODE_DRAIN, MODE_MIX} mix_t;

  typedef struct packed {
    logic [STAT_W-1:0]   status;
    logic [HANDLE_W-1:0] handle;
    logic [SIZE_W-1:0]   bytes;
    logic [SIZE_W-1:0]   byte_pos;
    logic                evicted;
    logic [HANDLE_W-1:0] evicted_handle;
  } reply_t;

  class ring_ledger;
    localparam int DEPTH = RING_DEPTH_DEF;
    logic [HANDLE_W-1:0] slot_handle[DEPTH];
    logic [SIZE_W-1:0]   slot_size[DEPTH];
    int     wr_idx, rd_idx, stored;
    bit     full;
    reply_t pending_replies[$];
    int     errors, checked;
    int     n_add, n_evict, n_read, n_empty, n_find, n_hit, n_unused;

    function new();
      wr_idx = 0;
      rd_idx = 0;
      stored = 0;
      full = 0;
    endfunction

    function int unsigned total_bytes();
      int unsigned sum;
      int idx;
      sum = 0;
      idx = rd_idx;
      for (int i = 0; i < stored; i++) begin
        sum += slot_size[idx];
        idx = (idx + 1) % DEPTH;
      end
      return sum;
    endfunction

    function reply_t predict_reply(logic [OP_W-1:0] op, logic [HANDLE_W-1:0] handle,
                                   logic [SIZE_W-1:0] size, logic [POS_W-1:0] pos);
      reply_t r;
      int unsigned remaining;
      int idx;
      bit hit;
      r = '0;
      case (op)
        OP_ADD: begin
          n_add++;
          if (full) begin
            r.evicted = 1'b1;
            r.evicted_handle = slot_handle[wr_idx];
            n_evict++;
          end
          slot_handle[wr_idx] = handle;
          slot_size[wr_idx] = size;
          wr_idx = (wr_idx + 1) % DEPTH;
          if (full) rd_idx = wr_idx;
          else stored++;
          if (wr_idx == rd_idx) full = 1;
        end
        OP_READ: begin
          n_read++;
          if (stored == 0) begin
            r.status = ST_EMPTY;
            n_empty++;
          end else begin
            r.handle = slot_handle[rd_idx];
            r.bytes = slot_size[rd_idx];
            rd_idx = (rd_idx + 1) % DEPTH;
            stored--;
            full = 0;
          end
        end
        OP_FIND: begin
          n_find++;
          remaining = pos;
          idx = rd_idx;
          hit = 0;
          for (int i = 0; i < stored && !hit; i++) begin
            if (remaining < slot_size[idx]) begin
              r.handle = slot_handle[idx];
              r.bytes = slot_size[idx];
              r.byte_pos = remaining[SIZE_W-1:0];
              hit = 1;
            end else begin
              remaining -= slot_size[idx];
              idx = (idx + 1) % DEPTH;
            end
          end
          if (hit) n_hit++;
          else r.status = ST_NOT_FOUND;
        end
        default: n_unused++;
      endcase
      return r;
    endfunction

    function void note_command(logic [OP_W-1:0] op, logic [HANDLE_W-1:0] handle,
                               logic [SIZE_W-1:0] size, logic [POS_W-1:0] pos);
      pending_replies.push_back(predict_reply(op, handle, size, pos));
    endfunction

    function int pending();
      return pending_replies.size();
    endfunction

    task report_mismatch(string what);
      $display("%0t: mismatch: %s", $realtime, what);
      errors++;
    endtask

    task check_reply(reply_t got);
      reply_t want;
      if (pending_replies.size() == 0) begin
        report_mismatch("result word with no command outstanding");
        return;
      end
      want = pending_replies.pop_front();
      checked++;
      if (got.status !== want.status)
        report_mismatch($sformatf("status %0d, want %0d", got.status, want.status));
      if (got.handle !== want.handle)
        report_mismatch($sformatf("entry_handle %h, want %h", got.handle, want.handle));
      if (got.bytes !== want.bytes)
        report_mismatch($sformatf("entry_bytes %h, want %h", got.bytes, want.bytes));
      if (got.byte_pos !== want.byte_pos)
        report_mismatch($sformatf("byte_in_entry %h, want %h", got.byte_pos, want.byte_pos));
      if (got.evicted !== want.evicted)
        report_mismatch($sformatf("evicted_valid %b, want %b", got.evicted, want.evicted));
      if (got.evicted_handle !== want.evicted_handle)
        report_mismatch($sformatf("evicted_handle %h, want %h",
                                  got.evicted_handle, want.evicted_handle));
    endtask
  endclass

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                start = 1'b0;
  logic                busy;
  logic [OP_W-1:0]     in_operation = OP_ADD;
  logic [HANDLE_W-1:0] in_new_handle = '0;
  logic [SIZE_W-1:0]   in_new_size = '0;
  logic [POS_W-1:0]    in_char_position = '0;
  logic                out_valid;
  logic [STAT_W-1:0]   out_status;
  logic [HANDLE_W-1:0] out_entry_handle;
  logic [SIZE_W-1:0]   out_entry_bytes;
  logic [SIZE_W-1:0]   out_byte_in_entry;
  logic                out_evicted_valid;
  logic [HANDLE_W-1:0] out_evicted_handle;

  ring_ledger ledger = new();
  int cycle_count = 0;

  overwriting_entry_ring_with_offset_find #(.RING_DEPTH(RING_DEPTH_DEF)) uut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_operation(in_operation), .in_new_handle(in_new_handle),
    .in_new_size(in_new_size), .in_char_position(in_char_position),
    .out_valid(out_valid), .out_status(out_status),
    .out_entry_handle(out_entry_handle), .out_entry_bytes(out_entry_bytes),
    .out_byte_in_entry(out_byte_in_entry), .out_evicted_valid(out_evicted_valid),
    .out_evicted_handle(out_evicted_handle)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d words outstanding", cycle_count,
               ledger.pending());
      $display("overwriting_entry_ring_with_offset_find_tb: FAIL");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1)
      ledger.check_reply('{out_status, out_entry_handle, out_entry_bytes,
                           out_byte_in_entry, out_evicted_valid, out_evicted_handle});
  end

  task automatic send_word(logic [OP_W-1:0] op, logic [HANDLE_W-1:0] handle,
                           logic [SIZE_W-1:0] size, logic [POS_W-1:0] pos);
    @(negedge clk);
    start <= 1'b1;
    in_operation <= op;
    in_new_handle <= handle;
    in_new_size <= size;
    in_char_position <= pos;
    do @(posedge clk); while (busy);
    ledger.note_command(op, handle, size, pos);
  endtask

  task automatic hold_off(int cycles);
    for (int i = 0; i < cycles; i++) begin
      @(negedge clk);
      start <= 1'b0;
      in_operation <= OP_W'($urandom_range(0, 3));
      in_new_handle <= $urandom;
      in_new_size <= SIZE_W'($urandom);
      in_char_position <= POS_W'($urandom);
    end
  endtask

  task automatic drain_replies();
    @(negedge clk);
    start <= 1'b0;
    while (ledger.pending() > 0) @(negedge clk);
  endtask

  function automatic logic [SIZE_W-1:0] pick_size();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return SIZE_W'($urandom_range(0, 15));
      4, 5, 6:    return SIZE_W'($urandom_range(0, 1023));
      7:          return '0;
      8:          return '1;
      default:    return SIZE_W'($urandom);
    endcase
  endfunction

  function automatic logic [POS_W-1:0] pick_offset();
    int unsigned total;
    total = ledger.total_bytes();
    if (total == 0) return ($urandom_range(0, 3) == 0) ? POS_W'($urandom) : '0;
    case ($urandom_range(0, 9))
      0:       return POS_W'(total);
      1:       return POS_W'(total - 1);
      2:       return POS_W'($urandom);
      3:       return '0;
      default: return POS_W'($urandom_range(0, total - 1));
    endcase
  endfunction

  function automatic logic [OP_W-1:0] pick_op(mix_t mode);
    int roll;
    int add_cut, read_cut;
    roll = $urandom_range(0, 99);
    case (mode)
      MODE_FILL:  begin add_cut = 70; read_cut = 80; end
      MODE_DRAIN: begin add_cut = 15; read_cut = 75; end
      default:    begin add_cut = 35; read_cut = 65; end
    endcase
    if (roll < add_cut) return OP_ADD;
    if (roll < read_cut) return OP_READ;
    if (roll < 98) return OP_FIND;
    return OP_UNUSED;
  endfunction

  initial begin
    mix_t mode;
    int   mode_left;
    bit   gaps_on;
    int   gap_left;
    logic [OP_W-1:0] op;

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    send_word(OP_READ, '1, '1, '1);
    send_word(OP_FIND, '0, '0, '0);
    send_word(OP_UNUSED, '1, '1, '1);
    send_word(OP_ADD, 32'hFFFF_FFFF, 20'h0, '0);
    send_word(OP_ADD, 32'h0000_0000, 20'hFFFFF, '1);
    send_word(OP_ADD, 32'h5A5A_5A5A, 20'h1, '0);
    send_word(OP_FIND, '0, '0, 24'h0);
    send_word(OP_FIND, '0, '0, 24'h0FFFFE);
    send_word(OP_FIND, '0, '0, 24'h0FFFFF);
    send_word(OP_FIND, '0, '0, 24'h100000);
    send_word(OP_FIND, '1, '1, 24'hFFFFFF);
    send_word(OP_UNUSED, '0, '0, '0);
    send_word(OP_READ, '0, '0, '0);
    send_word(OP_READ, '0, '0, '0);
    send_word(OP_READ, '0, '0, '0);
    send_word(OP_READ, '0, '0, '0);
    send_word(OP_FIND, '0, '0, '0);
    drain_replies();

    mode = MODE_FILL;
    mode_left = 40;
    gaps_on = 1;
    gap_left = 60;
    for (int n = 0; n < RANDOM_WORDS; n++) begin
      if (mode_left == 0) begin
        mode = mix_t'($urandom_range(0, 2));
        mode_left = $urandom_range(20, 60);
      end
      mode_left--;
      if (gap_left == 0) begin
        gaps_on = $urandom_range(0, 2) != 0;
        gap_left = $urandom_range(30, 80);
      end
      gap_left--;
      if (n == RANDOM_WORDS / 2) drain_replies();

      op = pick_op(mode);
      send_word(op, $urandom, pick_size(), op == OP_FIND ? pick_offset() : POS_W'($urandom));
      if (gaps_on && n < CALM_FROM && $urandom_range(0, 3) == 0)
        hold_off($urandom_range(1, 18));
    end

    drain_replies();
    repeat (25) @(posedge clk);

    $display("covered %0d adds (%0d overwrites), %0d reads (%0d on empty ring)",
             ledger.n_add, ledger.n_evict, ledger.n_read, ledger.n_empty);
    $display("%0d finds (%0d hits), %0d unused codes; %0d result words checked",
             ledger.n_find, ledger.n_hit, ledger.n_unused, ledger.checked);
    if (ledger.errors == 0 && ledger.pending() == 0) begin
      $display("overwriting_entry_ring_with_offset_find_tb: PASS");
    end else begin
      $display("%0d mismatches, %0d words outstanding", ledger.errors, ledger.pending());
      $display("overwriting_entry_ring_with_offset_find_tb: FAIL");
    end
    $finish;
  end

endmodule
